>>> sv/sc1kd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc1kd_pkg
// Types and constants shared by the set-1 scancode key event decoder.
// ----------------------------------------------------------------------------
package sc1kd_pkg;

    // Field widths.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CODE_W      = 7;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = CODE_W;

    // Escape prefix byte and the bit that marks a release.
    localparam logic [BYTE_W-1:0] PREFIX_BYTE = 8'hE0;
    localparam int unsigned       RELEASE_BIT = 7;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEFT_SHIFT  = 3'd0,
        CFG_RIGHT_SHIFT = 3'd1,
        CFG_CONTROL     = 3'd2,
        CFG_ALTERNATE   = 3'd3,
        CFG_DELETE      = 3'd4
    } cfg_reg_e;

    // Reset values of the configuration registers.
    localparam logic [CODE_W-1:0] RST_LEFT_SHIFT  = 7'd42;
    localparam logic [CODE_W-1:0] RST_RIGHT_SHIFT = 7'd54;
    localparam logic [CODE_W-1:0] RST_CONTROL     = 7'd29;
    localparam logic [CODE_W-1:0] RST_ALTERNATE   = 7'd56;
    localparam logic [CODE_W-1:0] RST_DELETE      = 7'd83;

    // Key codes held in the configuration registers.
    typedef struct packed {
        logic [CODE_W-1:0] left_shift;
        logic [CODE_W-1:0] right_shift;
        logic [CODE_W-1:0] control;
        logic [CODE_W-1:0] alternate;
        logic [CODE_W-1:0] delete_key;
    } cfg_codes_t;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic prefix_pending;
        logic left_shift_held;
        logic right_shift_held;
        logic control_held;
        logic alternate_held;
    } key_state_t;

    // One key event as it leaves the block.
    typedef struct packed {
        logic              pressed;
        logic [CODE_W-1:0] key_code;
        logic              escaped;
        logic              shift_active;
        logic              control_active;
        logic              alternate_active;
        logic              reboot_request;
    } key_event_t;

endpackage

>>> sv/sc1kd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc1kd_byte_if
// Valid/ready channel that carries one raw scancode byte per transaction.
// ----------------------------------------------------------------------------
interface sc1kd_byte_if
    import sc1kd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

>>> sv/sc1kd_event_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc1kd_event_if
// Valid/ready channel that carries one decoded key event per transaction.
// ----------------------------------------------------------------------------
interface sc1kd_event_if
    import sc1kd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              pressed;
    logic [CODE_W-1:0] key_code;
    logic              escaped;
    logic              shift_active;
    logic              control_active;
    logic              alternate_active;
    logic              reboot_request;

    modport source (
        output valid, output pressed, output key_code, output escaped,
        output shift_active, output control_active, output alternate_active,
        output reboot_request, input ready
    );
    modport sink (
        input valid, input pressed, input key_code, input escaped,
        input shift_active, input control_active, input alternate_active,
        input reboot_request, output ready
    );
endinterface

>>> sv/sc1kd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc1kd_cfg_regs
// Write-only register file holding the modifier and delete key codes.
// ----------------------------------------------------------------------------
module sc1kd_cfg_regs
    import sc1kd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   write_en,
    input  logic [CFG_INDEX_W-1:0] index,
    input  logic [CFG_DATA_W-1:0]  data,
    output cfg_codes_t             codes
);

    cfg_codes_t codes_reg;
    cfg_codes_t codes_next;

    // Decode the register index; indexes past the list are ignored.
    always_comb
    begin
        codes_next = codes_reg;
        if (write_en)
        begin
            case (index)
                CFG_LEFT_SHIFT:  codes_next.left_shift  = data[CODE_W-1:0];
                CFG_RIGHT_SHIFT: codes_next.right_shift = data[CODE_W-1:0];
                CFG_CONTROL:     codes_next.control     = data[CODE_W-1:0];
                CFG_ALTERNATE:   codes_next.alternate   = data[CODE_W-1:0];
                CFG_DELETE:      codes_next.delete_key  = data[CODE_W-1:0];
                default:         codes_next = codes_reg;
            endcase
        end
    end

    // Register storage with the documented reset codes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.left_shift  <= RST_LEFT_SHIFT;
            codes_reg.right_shift <= RST_RIGHT_SHIFT;
            codes_reg.control     <= RST_CONTROL;
            codes_reg.alternate   <= RST_ALTERNATE;
            codes_reg.delete_key  <= RST_DELETE;
        end
        else
        begin
            codes_reg <= codes_next;
        end
    end

    assign codes = codes_reg;

endmodule

>>> sv/sc1kd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc1kd_decode
// Combinational decode of one scancode byte against the current key state.
// ----------------------------------------------------------------------------
module sc1kd_decode
    import sc1kd_pkg::*;
(
    input  logic [BYTE_W-1:0] scan_byte,
    input  cfg_codes_t        codes,
    input  key_state_t        state,
    output key_state_t        state_next,
    output logic              emit,
    output key_event_t        key_event
);

    logic              is_prefix;
    logic              down;
    logic [CODE_W-1:0] code;
    logic              hit_left;
    logic              hit_right;
    logic              hit_control;
    logic              hit_alternate;
    logic              dropped;

    assign is_prefix = (scan_byte == PREFIX_BYTE);
    assign down      = ~scan_byte[RELEASE_BIT];
    assign code      = scan_byte[CODE_W-1:0];

    // Modifier match; the first register in list order wins on shared codes.
    assign hit_left      = (code == codes.left_shift);
    assign hit_right     = !hit_left && (code == codes.right_shift);
    assign hit_control   = !hit_left && !hit_right && (code == codes.control);
    assign hit_alternate = !hit_left && !hit_right && !hit_control
                           && (code == codes.alternate);

    // A modifier that is already in the requested state is dropped.
    assign dropped = (hit_left      && (state.left_shift_held  == down))
                  || (hit_right     && (state.right_shift_held == down))
                  || (hit_control   && (state.control_held     == down))
                  || (hit_alternate && (state.alternate_held   == down));

    // Next state: the prefix only sets the pending flag, any other byte clears it.
    always_comb
    begin
        state_next = state;
        if (is_prefix)
        begin
            state_next.prefix_pending = 1'b1;
        end
        else
        begin
            state_next.prefix_pending = 1'b0;
            if (hit_left)
            begin
                state_next.left_shift_held = down;
            end
            if (hit_right)
            begin
                state_next.right_shift_held = down;
            end
            if (hit_control)
            begin
                state_next.control_held = down;
            end
            if (hit_alternate)
            begin
                state_next.alternate_held = down;
            end
        end
    end

    assign emit = !is_prefix && !dropped;

    // Event fields reflect the modifier state after this byte.
    always_comb
    begin
        key_event.pressed          = down;
        key_event.key_code         = code;
        key_event.escaped          = state.prefix_pending;
        key_event.shift_active     = state_next.left_shift_held
                                     | state_next.right_shift_held;
        key_event.control_active   = state_next.control_held;
        key_event.alternate_active = state_next.alternate_held;
        key_event.reboot_request   = down && (code == codes.delete_key)
                                     && state_next.control_held
                                     && state_next.alternate_held;
    end

endmodule

>>> sv/scancode_set1_key_event_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_set1_key_event_decoder
// Turns a stream of set-1 scancode bytes into key events with modifier flags.
// ----------------------------------------------------------------------------
// The block accepts one scancode byte per clock cycle while the output is not
// stalled and returns at most one key event per byte. A byte is held in an
// input register, decoded against the held modifier state in one pass, and
// the event is placed in a result register; the modifier state updates in
// the same cycle, so consecutive bytes follow each other with no gap. The
// 0xE0 prefix and repeated modifier presses or releases produce no event.
// The modifier and delete key codes are set through the write port at
// register indexes 0 to 4 and should be written only while no byte is in
// flight.
// ----------------------------------------------------------------------------
module scancode_set1_key_event_decoder
    import sc1kd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sc1kd_byte_if.sink             byte_in,
    sc1kd_event_if.source          event_out
);

    cfg_codes_t        codes;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [BYTE_W-1:0] in_byte_next;

    key_state_t        state_reg;
    key_state_t        state_next;
    key_state_t        state_decoded;

    logic              out_valid_reg;
    logic              out_valid_next;
    key_event_t        out_event_reg;
    key_event_t        out_event_next;

    logic              emit;
    key_event_t        key_event;
    logic              advance;
    logic              take_byte;

    // Configuration registers.
    sc1kd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .write_en (cfg_write_en),
        .index    (cfg_index),
        .data     (cfg_data),
        .codes    (codes)
    );

    // Single-pass decode of the registered byte.
    sc1kd_decode u_decode (
        .scan_byte  (in_byte_reg),
        .codes      (codes),
        .state      (state_reg),
        .state_next (state_decoded),
        .emit       (emit),
        .key_event  (key_event)
    );

    // Handshake: the held byte moves on whenever the result slot is free.
    assign advance   = in_valid_reg && (!out_valid_reg || event_out.ready);
    assign byte_in.ready = !in_valid_reg || advance;
    assign take_byte = byte_in.valid && byte_in.ready;

    // Next values of the input stage, state and result stage.
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;

        if (take_byte)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = byte_in.scan_byte;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (advance)
        begin
            state_next     = state_decoded;
            out_valid_next = emit;
            out_event_next = key_event;
        end
        else if (event_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_byte_reg   <= in_byte_next;
        out_event_reg <= out_event_next;
    end

    // Drive the output channel from the result register.
    assign event_out.valid            = out_valid_reg;
    assign event_out.pressed          = out_event_reg.pressed;
    assign event_out.key_code         = out_event_reg.key_code;
    assign event_out.escaped          = out_event_reg.escaped;
    assign event_out.shift_active     = out_event_reg.shift_active;
    assign event_out.control_active   = out_event_reg.control_active;
    assign event_out.alternate_active = out_event_reg.alternate_active;
    assign event_out.reboot_request   = out_event_reg.reboot_request;

endmodule
